/* hw/rtl/assert_macros.svh */
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCPRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCPRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tcprc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcprc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int WINDOW_BITS   = 32;
    localparam int ACK_BITS      = 16;
    localparam int CFG_BITS      = 32;
    localparam int MINW_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;

    // n*n, then shifted up by the fraction width for the divide
    localparam int SQ_BITS       = 2 * ACK_BITS;
    localparam int DVD_BITS      = SQ_BITS + FRACTION_BITS;
    localparam int SUM_BITS      = ((WINDOW_BITS > SQ_BITS) ? WINDOW_BITS : SQ_BITS) + 2;
    localparam int DIV_CNT_BITS  = $clog2(DVD_BITS + 1);

    typedef logic [WINDOW_BITS-1:0]   win_t;
    typedef logic [FRACTION_BITS-1:0] frac_t;

    localparam win_t WIN_MAX        = '1;
    localparam win_t RESET_INIT_WIN = win_t'(10);
    localparam logic [MINW_BITS-1:0] RESET_MIN_WIN = MINW_BITS'(2);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_INIT_WIN = 2'd0,
        REG_SSTHRESH = 2'd1,
        REG_MIN_WIN  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_ACK  = 1'b0,
        OP_LOSS = 1'b1
    } op_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic loss;
        logic phase;
        logic div_done;
    } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/tcprc_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tcprc_req_if import tcprc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [ACK_BITS-1:0] packets_acked;

    modport source (output valid, operation, packets_acked, input ready);
    modport sink   (input valid, operation, packets_acked, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tcprc_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tcprc_rsp_if import tcprc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [WINDOW_BITS-1:0] window;
    logic                   in_avoidance;

    modport source (output valid, window, in_avoidance, input ready);
    modport sink   (input valid, window, in_avoidance, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tcp_reno_cwnd_update.sv */
// Reno congestion window in 32.16 fixed point with a slow-start/avoidance flag. One event
// at a time is taken on req and one result is returned on rsp for each. A loss, or an ack
// in slow start, goes from capture through check to commit; an ack in avoidance also
// waits in a divide state on the restoring divider, which forms n*n/window one quotient bit
// per cycle over the 48-bit dividend. The next event is taken as soon as the result sits in
// the output register, even if rsp has not yet taken it. Registers (cfg_index): 0 initial
// window, loaded into the window at once; 1 slow-start threshold, zero meaning never;
// 2 minimum window after a loss. Write them only while no event is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tcp_reno_cwnd_update import tcprc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data,
    tcprc_req_if.sink                    req,
    tcprc_rsp_if.source                  rsp
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;
    logic    req_ready;
    logic    rsp_valid;
    win_t    rsp_window;
    logic    rsp_in_avoidance;

    tcprc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .cmd       (dp_cmd),
        .sts       (dp_sts)
    );

    tcprc_dp u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .req_operation     (req.operation),
        .req_packets_acked (req.packets_acked),
        .cmd               (dp_cmd),
        .sts               (dp_sts),
        .rsp_window        (rsp_window),
        .rsp_in_avoidance  (rsp_in_avoidance)
    );

    assign req.ready        = req_ready;
    assign rsp.valid        = rsp_valid;
    assign rsp.window       = rsp_window;
    assign rsp.in_avoidance = rsp_in_avoidance;

    `TCPRC_ASSERT_IMP(a_window_nonzero, rsp.valid, rsp.window != '0, "window result is zero")
    `TCPRC_ASSERT_NXT(a_phase_sticky, dp_sts.phase, dp_sts.phase, "left avoidance")
    `TCPRC_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second event taken")
    `TCPRC_ASSERT_NXT(a_commit_shows, dp_cmd.commit, rsp.valid, "result not presented")

endmodule

`default_nettype wire

/* hw/rtl/tcprc_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcprc_div import tcprc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DVD_BITS-1:0] dividend,
    input  wire win_t                divisor,
    output logic      [DVD_BITS-1:0] quotient,
    output logic                     done
);

    win_t                    rem_reg;
    win_t                    dsr_reg;
    logic [DVD_BITS-1:0]     quo_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [WINDOW_BITS:0]    rem_shift;
    logic [WINDOW_BITS:0]    diff;
    logic                    take;
    win_t                    rem_next;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DVD_BITS-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        take      = !diff[WINDOW_BITS];
        rem_next  = take ? diff[WINDOW_BITS-1:0] : rem_shift[WINDOW_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(DVD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
                if (cnt_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVD_BITS-2:0], take};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/tcprc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcprc_ctrl import tcprc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   fast_path;

    always_comb
    begin
        out_free  = !out_valid_reg || rsp_ready;
        // loss and slow-start acks need no divide
        fast_path = sts.loss || !sts.phase;

        cmd.capture   = (state_reg == S_IDLE) && req_valid;
        cmd.div_start = (state_reg == S_CHECK) && !fast_path;
        cmd.commit    = (state_reg == S_COMMIT) && out_free;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = fast_path ? S_COMMIT : S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/tcprc_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcprc_dp import tcprc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data,
    input  wire logic                    req_operation,
    input  wire logic [ACK_BITS-1:0]     req_packets_acked,
    input  wire dp_cmd_t                 cmd,
    output dp_sts_t                      sts,
    output win_t                         rsp_window,
    output logic                         rsp_in_avoidance
);

    win_t                  win_int_reg;
    frac_t                 win_frac_reg;
    logic                  phase_reg;
    logic [CFG_BITS-1:0]   ssthresh_reg;
    logic [MINW_BITS-1:0]  min_win_reg;
    op_t                   op_reg;
    logic [ACK_BITS-1:0]   n_reg;
    logic [SQ_BITS-1:0]    sq_reg;
    win_t                  out_win_reg;
    logic                  out_phase_reg;

    win_t                  win_int_next;
    frac_t                 win_frac_next;
    logic                  phase_next;

    logic [DVD_BITS-1:0]   quot;
    logic                  div_done;
    win_t                  divisor;

    win_t                  load_val;
    win_t                  half;
    win_t                  min_ext;
    win_t                  loss_int;
    logic [WINDOW_BITS:0]  ss_sum;
    logic                  ss_sat;
    win_t                  ss_int;
    logic                  ss_enter;
    logic [FRACTION_BITS:0] frac_sum;
    logic [SUM_BITS-1:0]   ca_sum;
    logic                  ca_sat;

    assign divisor = (win_int_reg == '0) ? win_t'(1) : win_int_reg;

    tcprc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({sq_reg, FRACTION_BITS'(0)}),
        .divisor  (divisor),
        .quotient (quot),
        .done     (div_done)
    );

    always_comb
    begin
        // window load from a register write: zero taken as one, clamp at max
        if (cfg_data == '0)
            load_val = win_t'(1);
        else if (cfg_data > CFG_BITS'(WIN_MAX))
            load_val = WIN_MAX;
        else
            load_val = cfg_data[WINDOW_BITS-1:0];

        // loss: ceil(window/2), floored at min window
        half     = (win_int_reg >> 1) + win_t'(win_int_reg[0]);
        min_ext  = win_t'(min_win_reg);
        loss_int = (half < min_ext) ? min_ext : half;
        if (loss_int == '0)
            loss_int = win_t'(1);

        // slow start
        ss_sum   = {1'b0, win_int_reg} + (WINDOW_BITS+1)'(n_reg);
        ss_sat   = ss_sum[WINDOW_BITS];
        ss_int   = ss_sat ? WIN_MAX : ss_sum[WINDOW_BITS-1:0];
        ss_enter = (ssthresh_reg != '0) && (CFG_BITS'(ss_int) >= ssthresh_reg);

        // avoidance: add quotient with carry out of the fraction
        frac_sum = {1'b0, win_frac_reg} + {1'b0, quot[FRACTION_BITS-1:0]};
        ca_sum   = SUM_BITS'(win_int_reg) + SUM_BITS'(quot[DVD_BITS-1:FRACTION_BITS])
                   + SUM_BITS'(frac_sum[FRACTION_BITS]);
        ca_sat   = ca_sum > SUM_BITS'(WIN_MAX);

        win_int_next  = win_int_reg;
        win_frac_next = win_frac_reg;
        phase_next    = phase_reg;
        case (op_reg)
            OP_LOSS:
            begin
                win_int_next  = loss_int;
                win_frac_next = '0;
            end
            OP_ACK:
            begin
                if (!phase_reg)
                begin
                    win_int_next = ss_int;
                    if (ss_sat || ss_enter)
                        win_frac_next = '0;
                    if (ss_enter)
                        phase_next = 1'b1;
                end
                else if (ca_sat)
                begin
                    win_int_next  = WIN_MAX;
                    win_frac_next = '0;
                end
                else
                begin
                    win_int_next  = ca_sum[WINDOW_BITS-1:0];
                    win_frac_next = frac_sum[FRACTION_BITS-1:0];
                end
            end
            default:
            begin
                win_int_next = win_int_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_int_reg  <= RESET_INIT_WIN;
            win_frac_reg <= '0;
            phase_reg    <= 1'b0;
            ssthresh_reg <= '0;
            min_win_reg  <= RESET_MIN_WIN;
        end
        else if (cmd.commit)
        begin
            win_int_reg  <= win_int_next;
            win_frac_reg <= win_frac_next;
            phase_reg    <= phase_next;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INIT_WIN:
                begin
                    win_int_reg  <= load_val;
                    win_frac_reg <= '0;
                end
                REG_SSTHRESH:
                begin
                    ssthresh_reg <= cfg_data;
                end
                REG_MIN_WIN:
                begin
                    min_win_reg <= cfg_data[MINW_BITS-1:0];
                end
                default:
                begin
                    min_win_reg <= min_win_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op_t'(req_operation);
            n_reg  <= req_packets_acked;
            sq_reg <= req_packets_acked * req_packets_acked;
        end
        if (cmd.commit)
        begin
            out_win_reg   <= win_int_next;
            out_phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        sts.loss     = (op_reg == OP_LOSS);
        sts.phase    = phase_reg;
        sts.div_done = div_done;
    end

    assign rsp_window       = out_win_reg;
    assign rsp_in_avoidance = out_phase_reg;

endmodule

`default_nettype wire
